@@ src/hpmc_pkg.sv @@
// Package: word types, queue entry type and constants of the half-pel predictor.
`default_nettype none
package hpmc_pkg;

	// Item kind codes
	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	// Rounding terms for the two- and four-sample averages
	localparam logic [1:0] ROUND_PAIR = 2'd1;
	localparam logic [1:0] ROUND_QUAD = 2'd2;

	// Entries in the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Input word
	typedef struct packed {
		logic       kind;
		logic       half_x;
		logic       half_y;
		logic       add_mode;
		logic [4:0] block_width;
		logic [4:0] block_height;
		logic [7:0] ref_pixel;
		logic [7:0] prior_pixel;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [7:0] pred_pixel;
		logic       last_of_block;
	} out_word_t;

	// One classified pixel, as queued for the back end
	typedef struct packed {
		logic [7:0] ref_pixel;
		logic [7:0] prior_pixel;
		logic       half_x;
		logic       half_y;
		logic       add_mode;
		logic       emit;
		logic       last;
	} op_t;

	// Queue status seen by the top level
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

@@ src/hpmc_front.sv @@
// Front end: takes words, tracks block header and window position, queues pixels.
`default_nettype none
module hpmc_front
	import hpmc_pkg::*;
#(
	parameter int unsigned MAX_BLOCK_SIDE = 16,
	parameter int unsigned IW = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire in_word_t      item,
	output logic               push,
	output op_t                op,
	output logic [IW-1:0]      col
);

	logic          active_q;
	logic          hx_q, hy_q, add_q;
	logic [IW-1:0] width_q, height_q;
	logic [IW-1:0] col_q, row_q;

	logic [IW-1:0] hdr_w, hdr_h;
	logic [IW:0]   win_w, win_h, col_inc, row_inc;
	logic          end_col, end_row, last, emit;

	// Header size, saturated to the largest block side
	always_comb begin
		if (int'(item.block_width) > MAX_BLOCK_SIDE) begin
			hdr_w = IW'(MAX_BLOCK_SIDE);
		end else begin
			hdr_w = IW'(item.block_width);
		end
		if (int'(item.block_height) > MAX_BLOCK_SIDE) begin
			hdr_h = IW'(MAX_BLOCK_SIDE);
		end else begin
			hdr_h = IW'(item.block_height);
		end
	end

	// Window position and classification of the current pixel
	always_comb begin
		win_w   = {1'b0, width_q} + (IW+1)'(hx_q);
		win_h   = {1'b0, height_q} + (IW+1)'(hy_q);
		col_inc = {1'b0, col_q} + (IW+1)'(1);
		row_inc = {1'b0, row_q} + (IW+1)'(1);
		end_col = col_inc >= win_w;
		end_row = row_inc >= win_h;
		last    = end_col && end_row;
		emit    = (col_q >= IW'(hx_q)) && (row_q >= IW'(hy_q));
	end

	assign push = accept && (item.kind == KIND_PIXEL) && active_q;
	assign col  = col_q;

	always_comb begin
		op.ref_pixel   = item.ref_pixel;
		op.prior_pixel = item.prior_pixel;
		op.half_x      = hx_q;
		op.half_y      = hy_q;
		op.add_mode    = add_q;
		op.emit        = emit;
		op.last        = last;
	end

	// Block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			hx_q     <= 1'b0;
			hy_q     <= 1'b0;
			add_q    <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (accept) begin
			if (item.kind == KIND_HEADER) begin
				hx_q     <= item.half_x;
				hy_q     <= item.half_y;
				add_q    <= item.add_mode;
				width_q  <= hdr_w;
				height_q <= hdr_h;
				col_q    <= '0;
				row_q    <= '0;
				active_q <= (hdr_w != '0) && (hdr_h != '0);
			end else if (active_q) begin
				if (last) begin
					active_q <= 1'b0;
					col_q    <= '0;
					row_q    <= '0;
				end else if (end_col) begin
					col_q <= '0;
					row_q <= row_inc[IW-1:0];
				end else begin
					col_q <= col_inc[IW-1:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ src/hpmc_queue.sv @@
// Short FIFO between the front and back ends.
`default_nettype none
module hpmc_queue
	import hpmc_pkg::*;
#(
	parameter int unsigned W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output queue_status_t     status
);

	logic [W-1:0]        mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push, do_pop;

	assign status.full  = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign status.empty = count_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rdata        = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ src/hpmc_back.sv @@
// Back end: line store, neighbour samples, rounded averaging and output register.
`default_nettype none
module hpmc_back
	import hpmc_pkg::*;
#(
	parameter int unsigned MAX_BLOCK_SIDE = 16,
	parameter int unsigned IW = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire op_t           head_op,
	input  wire logic [IW-1:0] head_col,
	output logic               pop,
	output logic               result_valid,
	input  wire logic          result_stall,
	output out_word_t          result
);

	localparam int unsigned SD = MAX_BLOCK_SIDE + 1;

	logic [7:0] row_store_q [SD];
	logic [7:0] left_q, above_left_q;
	logic       valid_q;
	out_word_t  result_q;

	logic [7:0] above, avg, pred;
	logic [9:0] sum_quad;
	logic [8:0] sum_pair, sum_prior;

	// Interpolation per half-pel mode, then optional averaging with the prior
	always_comb begin
		above    = row_store_q[head_col];
		sum_quad = 10'(above_left_q) + 10'(above) + 10'(left_q)
			+ 10'(head_op.ref_pixel) + 10'(ROUND_QUAD);
		sum_pair = '0;
		avg      = head_op.ref_pixel;
		case ({head_op.half_x, head_op.half_y})
			2'b11: avg = sum_quad[9:2];
			2'b10: begin
				sum_pair = 9'(left_q) + 9'(head_op.ref_pixel) + 9'(ROUND_PAIR);
				avg      = sum_pair[8:1];
			end
			2'b01: begin
				sum_pair = 9'(above) + 9'(head_op.ref_pixel) + 9'(ROUND_PAIR);
				avg      = sum_pair[8:1];
			end
			default: avg = head_op.ref_pixel;
		endcase
		sum_prior = 9'(head_op.prior_pixel) + 9'(avg) + 9'(ROUND_PAIR);
		pred      = head_op.add_mode ? sum_prior[8:1] : avg;
	end

	assign pop          = head_valid && (!valid_q || !result_stall);
	assign result_valid = valid_q;
	assign result       = result_q;

	// Line store; its values are never used before written within a block
	always_ff @(posedge clk) begin
		if (pop) begin
			row_store_q[head_col] <= head_op.ref_pixel;
		end
	end

	// Output word
	always_ff @(posedge clk) begin
		if (pop && head_op.emit) begin
			result_q.pred_pixel    <= pred;
			result_q.last_of_block <= head_op.last;
		end
	end

	// Neighbour samples and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			above_left_q <= '0;
			valid_q      <= 1'b0;
		end else begin
			if (pop) begin
				left_q       <= head_op.ref_pixel;
				above_left_q <= above;
			end
			if (pop && head_op.emit) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/half_pel_motion_compensation.sv @@
// Top level of the half-pel motion-compensated block predictor.
// Usage:
//  Input channel item/item_valid/item_stall carries headers (kind 0) and
//  reference pixels (kind 1). A header sets block size, half-pel flags and
//  add mode; then (width+half_x) x (height+half_y) window pixels follow in
//  raster order. Pixels outside an active block are dropped.
//  Output channel result/result_valid/result_stall gives one prediction
//  word per window pixel at or past the half-pel offset, with
//  last_of_block set on the block's final pixel.
//  Throughput: one word per cycle while result_stall is low, set by the
//  combinational averaging in the back end. A pixel is written into the
//  queue at its accepting edge and averaged into the output register at
//  the edge on which the back end pops it; the result then holds until taken.
//  The front end stalls only when the four-entry queue is full, so words
//  keep flowing while a result waits. A stalled result holds in its
//  register; the queue then fills and backs up the input.
//  Reset clears control state and neighbour samples; line store values are
//  only used after the same block has written them.
`default_nettype none
module half_pel_motion_compensation
	import hpmc_pkg::*;
#(
	parameter int unsigned MAX_BLOCK_SIDE = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_stall,
	input  wire in_word_t  item,
	output logic           result_valid,
	input  wire logic      result_stall,
	output out_word_t      result
);

	localparam int unsigned IW = $clog2(MAX_BLOCK_SIDE + 1);
	localparam int unsigned QW = $bits(op_t) + IW;

	logic          accept, push, pop;
	op_t           push_op, head_op;
	logic [IW-1:0] push_col, head_col;
	queue_status_t qstat;

	assign item_stall = qstat.full;
	assign accept     = item_valid && !item_stall;

	hpmc_front #(
		.MAX_BLOCK_SIDE(MAX_BLOCK_SIDE),
		.IW(IW)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (item),
		.push  (push),
		.op    (push_op),
		.col   (push_col)
	);

	hpmc_queue #(
		.W(QW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({push_op, push_col}),
		.pop   (pop),
		.rdata ({head_op, head_col}),
		.status(qstat)
	);

	hpmc_back #(
		.MAX_BLOCK_SIDE(MAX_BLOCK_SIDE),
		.IW(IW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (!qstat.empty),
		.head_op     (head_op),
		.head_col    (head_col),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

`ifndef NO_ASSERTIONS
	// Queue never reports full and empty together
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue full and empty together");

	// A pixel is queued only for an accepted word
	a_push_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept)
		else $error("queue push without accepted word");

	// A header never reaches the back end
	a_header_not_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.kind == KIND_HEADER) |-> !push)
		else $error("header word queued");

	// A new result is loaded only when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> !pop)
		else $error("back end popped while result stalled");
`endif

endmodule
`default_nettype wire
